[sv/assert_macros.svh]
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define B64D_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// The condition must never be true at a clock edge outside reset.
`define B64D_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

[sv/b64d_pkg.sv]
// Shared constants, types and the alphabet lookup of the base64 decoder.
package b64d_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 24;
    localparam int CAP_RESET           = 65535;
    localparam int CHAR_WIDTH          = 8;
    localparam int QUAD_SIZE           = 4;
    localparam int WORD_WIDTH          = 24;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [7:0] PAD_CHAR    = 8'd61;
    localparam logic [5:0] ALPHA_SIZE  = 6'd26;
    localparam logic [5:0] PLUS_CODE   = 6'(2 * 26 + 10);
    localparam logic [5:0] SLASH_CODE  = 6'(2 * 26 + 11);

    // One decode job handed from the front to the back.
    typedef struct packed {
        logic [WORD_WIDTH-1:0] word;
        logic [1:0]            nbytes;
        logic                  eom;
        logic                  status;
    } job_t;

    // Returns {valid, sextet}; valid is 0 for characters outside the alphabet.
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c inside {[8'd65:8'd90]}) begin
            r = {1'b1, 6'(c - 8'd65)};
        end else if (c inside {[8'd97:8'd122]}) begin
            r = {1'b1, 6'(c - 8'd97) + ALPHA_SIZE};
        end else if (c inside {[8'd48:8'd57]}) begin
            r = {1'b1, 6'(c - 8'd48) + 6'(2 * 26)};
        end else if (c == 8'd43) begin
            r = {1'b1, PLUS_CODE};
        end else if (c == 8'd47) begin
            r = {1'b1, SLASH_CODE};
        end
        return r;
    endfunction

endpackage

[sv/b64d_ifs.sv]
// Valid/ready stream interfaces for the decoder's input and output channels.
interface b64d_in_if;
    logic                               valid;
    logic                               ready;
    logic [b64d_pkg::CHAR_WIDTH-1:0]    in_char;
    logic                               in_last;

    modport source (output valid, in_char, in_last, input ready);
    modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_message;
    logic       status;

    modport source (output valid, out_byte, has_byte, end_of_message, status, input ready);
    modport sink   (input valid, out_byte, has_byte, end_of_message, status, output ready);
endinterface

[sv/b64d_front.sv]
// Front end: classifies characters, gathers quads and checks capacity.
`include "assert_macros.svh"

module b64d_front #(
    parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [COUNT_WIDTH-1:0] cfg_wdata,
    b64d_in_if.sink                in_stream,
    input  logic                   q_full,
    output logic                   push,
    output b64d_pkg::job_t         job
);

    logic [COUNT_WIDTH-1:0] cap_reg, cap_next;
    logic [COUNT_WIDTH-1:0] room_reg, room_next;
    logic [5:0]             store_reg [b64d_pkg::QUAD_SIZE];
    logic [5:0]             store_next [b64d_pkg::QUAD_SIZE];
    logic [1:0]             cnt_reg, cnt_next;
    logic [2:0]             pads_reg, pads_next;
    logic                   bad_reg, bad_next;
    logic                   halted_reg, halted_next;
    logic                   ovf_reg, ovf_next;
    logic                   busy_reg, busy_next;

    logic       fire;
    logic [6:0] lk;
    logic       is_pad;
    logic       kept;
    logic [5:0] store1 [b64d_pkg::QUAD_SIZE];
    logic [2:0] cnt1;
    logic [2:0] pads1;
    logic       bad1;
    logic       full_quad;
    logic       pad_tail;
    logic       finish;
    logic [2:0] fin_pads;
    logic [1:0] len;
    logic       too_big;

    assign in_stream.ready = !q_full;
    assign fire            = in_stream.valid && !q_full;

    always_comb
    begin
        lk     = b64d_pkg::sextet_lookup(in_stream.in_char);
        is_pad = (in_stream.in_char == b64d_pkg::PAD_CHAR);
        kept   = !halted_reg && (is_pad || lk[6]);
        store1 = store_reg;
        cnt1   = {1'b0, cnt_reg};
        pads1  = pads_reg;
        bad1   = bad_reg;
        if (kept)
        begin
            store1[cnt_reg] = is_pad ? 6'd0 : lk[5:0];
            cnt1            = {1'b0, cnt_reg} + 3'd1;
            if (is_pad)
            begin
                pads1 = (pads_reg != 3'd7) ? pads_reg + 3'd1 : pads_reg;
            end
            else
            begin
                // A real character after '=' spoils the quad.
                if (pads_reg != 3'd0)
                begin
                    bad1 = 1'b1;
                end
                pads1 = 3'd0;
            end
        end
        full_quad = (cnt1 == 3'd4);
        // At message end a partial quad is completed with '=' characters.
        pad_tail  = in_stream.in_last && !halted_reg && !full_quad && (cnt1 != 3'd0);
        finish    = full_quad || pad_tail;
        fin_pads  = full_quad ? pads1 : pads1 + (3'd4 - cnt1);
        len       = (!bad1 && fin_pads < 3'd3) ? 2'(3'd3 - fin_pads) : 2'd0;
        too_big   = finish && (COUNT_WIDTH'(len) > room_reg);

        job.word   = {store1[0], store1[1], store1[2], store1[3]};
        job.nbytes = (finish && !too_big) ? len : 2'd0;
        job.eom    = in_stream.in_last;
        job.status = ovf_reg || too_big;
        push       = fire && (in_stream.in_last || (finish && !too_big && len != 2'd0));
    end

    always_comb
    begin
        cap_next    = cap_reg;
        room_next   = room_reg;
        store_next  = store_reg;
        cnt_next    = cnt_reg;
        pads_next   = pads_reg;
        bad_next    = bad_reg;
        halted_next = halted_reg;
        ovf_next    = ovf_reg;
        busy_next   = busy_reg;
        if (cfg_we)
        begin
            cap_next = cfg_wdata;
            // The running count only follows a new capacity between messages.
            if (!busy_reg)
            begin
                room_next = cfg_wdata;
            end
        end
        if (fire)
        begin
            if (in_stream.in_last)
            begin
                room_next   = cap_next;
                store_next  = '{default: 6'd0};
                cnt_next    = 2'd0;
                pads_next   = 3'd0;
                bad_next    = 1'b0;
                halted_next = 1'b0;
                ovf_next    = 1'b0;
                busy_next   = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
                if (finish)
                begin
                    store_next = '{default: 6'd0};
                    cnt_next   = 2'd0;
                    pads_next  = 3'd0;
                    bad_next   = 1'b0;
                    if (too_big)
                    begin
                        halted_next = 1'b1;
                        ovf_next    = 1'b1;
                    end
                    else
                    begin
                        room_next = room_reg - COUNT_WIDTH'(len);
                        if (len != 2'd3)
                        begin
                            halted_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    store_next = store1;
                    cnt_next   = cnt1[1:0];
                    pads_next  = pads1;
                    bad_next   = bad1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= COUNT_WIDTH'(b64d_pkg::CAP_RESET);
            room_reg   <= COUNT_WIDTH'(b64d_pkg::CAP_RESET);
            store_reg  <= '{default: 6'd0};
            cnt_reg    <= 2'd0;
            pads_reg   <= 3'd0;
            bad_reg    <= 1'b0;
            halted_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            cap_reg    <= cap_next;
            room_reg   <= room_next;
            store_reg  <= store_next;
            cnt_reg    <= cnt_next;
            pads_reg   <= pads_next;
            bad_reg    <= bad_next;
            halted_reg <= halted_next;
            ovf_reg    <= ovf_next;
            busy_reg   <= busy_next;
        end
    end

    `B64D_ASSERT(a_end_clears, (fire && in_stream.in_last) |=> (!busy_reg && cnt_reg == 2'd0))
    `B64D_ASSERT_NEVER(a_halted_holds_chars, halted_reg && cnt_reg != 2'd0)

endmodule

[sv/b64d_queue.sv]
// Short job queue between the front end and the byte emitter.
`include "assert_macros.svh"

module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::job_t push_job,
    input  logic           pop,
    output b64d_pkg::job_t head_job,
    output logic           empty,
    output logic           full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::job_t  slots_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign empty    = (count_reg == CW'(0));
    assign full     = (count_reg == CW'(DEPTH));
    assign head_job = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= PW'(0);
            rd_ptr_reg <= PW'(0);
            count_reg  <= CW'(0);
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `B64D_ASSERT_NEVER(a_push_when_full, push && full)
    `B64D_ASSERT_NEVER(a_pop_when_empty, pop && empty)
    `B64D_ASSERT(a_count_bound, count_reg <= CW'(DEPTH))

endmodule

[sv/b64d_back.sv]
// Back end: turns queued jobs into byte beats and the end-of-message beat.
`include "assert_macros.svh"

module b64d_back (
    input  logic           clk,
    input  logic           rst_n,
    input  b64d_pkg::job_t head_job,
    input  logic           empty,
    output logic           pop,
    b64d_out_if.source     out_stream
);

    logic [1:0] beat_reg, beat_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       has_reg, has_next;
    logic       eom_reg, eom_next;
    logic       status_reg, status_next;
    logic       take;

    assign out_stream.valid          = valid_reg;
    assign out_stream.out_byte       = byte_reg;
    assign out_stream.has_byte       = has_reg;
    assign out_stream.end_of_message = eom_reg;
    assign out_stream.status         = status_reg;

    // The output register refills whenever it is empty or being drained and a job is queued.
    assign take = (!valid_reg || out_stream.ready) && !empty;

    always_comb
    begin
        pop         = 1'b0;
        beat_next   = beat_reg;
        byte_next   = byte_reg;
        has_next    = has_reg;
        eom_next    = eom_reg;
        status_next = status_reg;
        valid_next  = out_stream.ready ? 1'b0 : valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
            if (beat_reg < head_job.nbytes)
            begin
                case (beat_reg)
                    2'd0:    byte_next = head_job.word[23:16];
                    2'd1:    byte_next = head_job.word[15:8];
                    default: byte_next = head_job.word[7:0];
                endcase
                has_next    = 1'b1;
                eom_next    = 1'b0;
                status_next = 1'b0;
                if (beat_reg == head_job.nbytes - 2'd1 && !head_job.eom)
                begin
                    pop       = 1'b1;
                    beat_next = 2'd0;
                end
                else
                begin
                    beat_next = beat_reg + 2'd1;
                end
            end
            else
            begin
                byte_next   = 8'd0;
                has_next    = 1'b0;
                eom_next    = 1'b1;
                status_next = head_job.status;
                pop         = 1'b1;
                beat_next   = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg  <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        has_reg    <= has_next;
        eom_reg    <= eom_next;
        status_reg <= status_next;
    end

    `B64D_ASSERT(a_end_beat_empty, (valid_reg && eom_reg) |-> (!has_reg && byte_reg == 8'd0))

endmodule

[sv/base64_stream_decoder.sv]
// Top level of the streaming base64 decoder.
// Takes one source character per cycle unless the four-entry job queue between the front
// end and the byte emitter is full, which is the only thing that drops ready. The emitter
// sends one beat per cycle while the queue holds a job and ready is high: up to three
// byte beats per completed quad, plus one end beat per message, so ordinary base64 text
// (three bytes per four characters) flows at full input rate. A result passes through
// the job queue and the emitter's output register. Output_capacity is written through
// cfg_we and cfg_wdata and applies to the next message if the current one has begun.
module base64_stream_decoder #(
    parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [COUNT_WIDTH-1:0] cfg_wdata,
    b64d_in_if.sink                in_stream,
    b64d_out_if.source             out_stream
);

    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    b64d_pkg::job_t push_job;
    b64d_pkg::job_t head_job;

    b64d_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_stream (in_stream),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    b64d_queue #(
        .DEPTH (b64d_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .empty      (q_empty),
        .pop        (pop),
        .out_stream (out_stream)
    );

endmodule
